// ----- rtl/vn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_pkg
// shared widths and defaults for the 3-d vector normalizer
// ----------------------------------------------------------------------------
package vn_pkg;
   localparam int COMP_W        = 32;
   localparam int UNIT_W        = 32;
   localparam int LEN_W         = 32;
   localparam int LEN_SQ_W      = 64;
   localparam int COMP_WIDTH_DEF = 32;
   localparam int UNIT_FRAC_DEF  = 30;
endpackage
`default_nettype wire

// ----- rtl/vn_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_req_if / vn_rsp_if
// valid/ready channels carrying input vectors and normalized results
// ----------------------------------------------------------------------------
interface vn_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [vn_pkg::COMP_W-1:0]    comp_x;
   logic signed [vn_pkg::COMP_W-1:0]    comp_y;
   logic signed [vn_pkg::COMP_W-1:0]    comp_z;
   modport source (output valid, comp_x, comp_y, comp_z, input ready);
   modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vn_pkg::UNIT_W-1:0]    unit_x;
   logic signed [vn_pkg::UNIT_W-1:0]    unit_y;
   logic signed [vn_pkg::UNIT_W-1:0]    unit_z;
   logic        [vn_pkg::LEN_W-1:0]     length;
   logic        [vn_pkg::LEN_SQ_W-1:0]  length_squared;
   logic                                is_zero;
   modport source (output valid, unit_x, unit_y, unit_z, length, length_squared, is_zero,
                   input ready);
   modport sink   (input valid, unit_x, unit_y, unit_z, length, length_squared, is_zero,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/vn_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// one root bit of the digit-by-digit square root, registered
// ----------------------------------------------------------------------------
module vn_sqrt_cell #(
   parameter int W      = vn_pkg::COMP_WIDTH_DEF,
   parameter int IDX    = 0,
   parameter int PASS_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                valid_in,
   input  wire logic [2*W-1:0]      sq_in,
   input  wire logic [W+1:0]        rem_in,
   input  wire logic [W-1:0]        root_in,
   input  wire logic [PASS_W-1:0]   pass_in,
   output logic                     valid_ff,
   output logic [2*W-1:0]           sq_ff,
   output logic [W+1:0]             rem_ff,
   output logic [W-1:0]             root_ff,
   output logic [PASS_W-1:0]        pass_ff
);
   import vn_pkg::*;

   logic [W+1:0] rem_shift;
   logic [W+1:0] trial;
   logic         take;
   logic [W+1:0] rem_in_nxt;
   logic [W-1:0] root_in_nxt;

   always_comb begin
      rem_shift   = {rem_in[W-1:0], sq_in[2*IDX+1 -: 2]};
      trial       = {root_in, 2'b01};
      take        = (rem_shift >= trial);
      rem_in_nxt  = take ? (rem_shift - trial) : rem_shift;
      root_in_nxt = {root_in[W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         rem_ff  <= rem_in_nxt;
         root_ff <= root_in_nxt;
         pass_ff <= pass_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/vn_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn_div_cell
// one quotient bit for the three component lanes, registered
// ----------------------------------------------------------------------------
module vn_div_cell #(
   parameter int W      = vn_pkg::COMP_WIDTH_DEF,
   parameter int QW     = vn_pkg::UNIT_FRAC_DEF + 1,
   parameter bit SHIFT  = 1'b1,
   parameter int PASS_W = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  valid_in,
   input  wire logic [W-1:0]          len_in,
   input  wire logic [2:0][W:0]       rem_in,
   input  wire logic [2:0][QW-1:0]    quo_in,
   input  wire logic [PASS_W-1:0]     pass_in,
   output logic                       valid_ff,
   output logic [W-1:0]               len_ff,
   output logic [2:0][W:0]            rem_ff,
   output logic [2:0][QW-1:0]         quo_ff,
   output logic [PASS_W-1:0]          pass_ff
);
   import vn_pkg::*;

   logic [2:0][W:0]    rem_s;
   logic [2:0]         take;
   logic [2:0][W:0]    rem_in_nxt;
   logic [2:0][QW-1:0] quo_in_nxt;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_s[i]      = SHIFT ? {rem_in[i][W-1:0], 1'b0} : rem_in[i];
         take[i]       = (rem_s[i] >= {1'b0, len_in});
         rem_in_nxt[i] = take[i] ? (rem_s[i] - {1'b0, len_in}) : rem_s[i];
         quo_in_nxt[i] = {quo_in[i][QW-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff  <= len_in;
         rem_ff  <= rem_in_nxt;
         quo_ff  <= quo_in_nxt;
         pass_ff <= pass_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/vector3_normalize.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_normalize
// pipeline: stages a, b and c, then one square-root cell per root bit, one
// divider cell per quotient bit and the result register
// throughput: one transaction per cycle; the whole pipe holds when the
// result register is full and not taken
// reset: synchronous, clears only the valid bits of the pipe
// ----------------------------------------------------------------------------
module vector3_normalize #(
   parameter int COMP_WIDTH     = vn_pkg::COMP_WIDTH_DEF,
   parameter int UNIT_FRAC_BITS = vn_pkg::UNIT_FRAC_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   vn_req_if.sink    req_chan,
   vn_rsp_if.source  rsp_chan
);
   import vn_pkg::*;

   localparam int W      = COMP_WIDTH;
   localparam int F      = UNIT_FRAC_BITS;
   localparam int QW     = F + 1;
   localparam int SP_W   = 3 + 3 * W;
   localparam int DP_W   = 3 + 2 * W;

   logic advance;
   logic out_valid_ff;

   assign advance        = ~out_valid_ff | rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage a: magnitude and sign
   logic              a_valid_ff;
   logic [2:0][W-1:0] a_mag_ff;
   logic [2:0]        a_neg_ff;
   logic [2:0][W-1:0] a_raw;
   logic [2:0][W-1:0] a_mag_in;
   logic [2:0]        a_neg_in;

   always_comb begin
      a_raw[0] = req_chan.comp_x[W-1:0];
      a_raw[1] = req_chan.comp_y[W-1:0];
      a_raw[2] = req_chan.comp_z[W-1:0];
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = a_raw[i][W-1];
         a_mag_in[i] = a_neg_in[i] ? (~a_raw[i] + 1'b1) : a_raw[i];
      end
   end

   // stage b: squares
   logic                b_valid_ff;
   logic [2:0][2*W-1:0] b_sq_ff;
   logic [2:0][W-1:0]   b_mag_ff;
   logic [2:0]          b_neg_ff;

   // stage c: sum of squares
   logic              c_valid_ff;
   logic [2*W-1:0]    c_sum_ff;
   logic [2:0][W-1:0] c_mag_ff;
   logic [2:0]        c_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_chan.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_mag_ff <= a_mag_in;
         a_neg_ff <= a_neg_in;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= (2*W)'(a_mag_ff[i]) * (2*W)'(a_mag_ff[i]);
         end
         b_mag_ff <= a_mag_ff;
         b_neg_ff <= a_neg_ff;
         c_sum_ff <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
         c_mag_ff <= b_mag_ff;
         c_neg_ff <= b_neg_ff;
      end
   end

   // square-root chain, most significant root bit first
   logic [W:0]            s_valid;
   logic [W:0][2*W-1:0]   s_sq;
   logic [W:0][W+1:0]     s_rem;
   logic [W:0][W-1:0]     s_root;
   logic [W:0][SP_W-1:0]  s_pass;

   assign s_valid[0] = c_valid_ff;
   assign s_sq[0]    = c_sum_ff;
   assign s_rem[0]   = '0;
   assign s_root[0]  = '0;
   assign s_pass[0]  = {c_neg_ff, c_mag_ff};

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      vn_sqrt_cell #(
         .W      (W),
         .IDX    (W - 1 - k),
         .PASS_W (SP_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (advance),
         .valid_in (s_valid[k]),
         .sq_in    (s_sq[k]),
         .rem_in   (s_rem[k]),
         .root_in  (s_root[k]),
         .pass_in  (s_pass[k]),
         .valid_ff (s_valid[k+1]),
         .sq_ff    (s_sq[k+1]),
         .rem_ff   (s_rem[k+1]),
         .root_ff  (s_root[k+1]),
         .pass_ff  (s_pass[k+1])
      );
   end

   // divider chain, one quotient bit per cell for all three lanes
   logic [2:0]        s_neg;
   logic [2:0][W-1:0] s_mag;

   assign {s_neg, s_mag} = s_pass[W];

   logic [QW:0]                d_valid;
   logic [QW:0][W-1:0]         d_len;
   logic [QW:0][2:0][W:0]      d_rem;
   logic [QW:0][2:0][QW-1:0]   d_quo;
   logic [QW:0][DP_W-1:0]      d_pass;

   assign d_valid[0] = s_valid[W];
   assign d_len[0]   = s_root[W];
   assign d_quo[0]   = '0;
   assign d_pass[0]  = {s_sq[W], s_neg};
   for (genvar i = 0; i < 3; i++) begin : g_rem0
      assign d_rem[0][i] = {1'b0, s_mag[i]};
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      vn_div_cell #(
         .W      (W),
         .QW     (QW),
         .SHIFT  (k != 0),
         .PASS_W (DP_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (advance),
         .valid_in (d_valid[k]),
         .len_in   (d_len[k]),
         .rem_in   (d_rem[k]),
         .quo_in   (d_quo[k]),
         .pass_in  (d_pass[k]),
         .valid_ff (d_valid[k+1]),
         .len_ff   (d_len[k+1]),
         .rem_ff   (d_rem[k+1]),
         .quo_ff   (d_quo[k+1]),
         .pass_ff  (d_pass[k+1])
      );
   end

   // result register
   logic [2*W-1:0]         f_sq;
   logic [2:0]             f_neg;
   logic                   f_zero;
   logic [2:0][UNIT_W-1:0] f_unit;

   logic [2:0][UNIT_W-1:0] unit_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [LEN_SQ_W-1:0]    len_sq_ff;
   logic                   zero_ff;

   always_comb begin
      {f_sq, f_neg} = d_pass[QW];
      f_zero        = (d_len[QW] == '0);
      for (int i = 0; i < 3; i++) begin
         if (f_zero) begin
            f_unit[i] = '0;
         end else if (f_neg[i]) begin
            f_unit[i] = '0 - UNIT_W'(d_quo[QW][i]);
         end else begin
            f_unit[i] = UNIT_W'(d_quo[QW][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= d_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         unit_ff   <= f_unit;
         len_ff    <= LEN_W'(d_len[QW]);
         len_sq_ff <= LEN_SQ_W'(f_sq);
         zero_ff   <= f_zero;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.unit_x         = unit_ff[0];
   assign rsp_chan.unit_y         = unit_ff[1];
   assign rsp_chan.unit_z         = unit_ff[2];
   assign rsp_chan.length         = len_ff;
   assign rsp_chan.length_squared = len_sq_ff;
   assign rsp_chan.is_zero        = zero_ff;
endmodule
`default_nettype wire

// ----- tb/sv/tb_vector3_normalize.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize
// self-checking bench for the 3-d vector normalizer: directed corner vectors
// and random vectors are sent with bursty valid, results are taken with
// random and long back-pressure, and every field is compared in order
// ----------------------------------------------------------------------------
module tb_vector3_normalize;
   import vn_pkg::*;

   localparam int LATENCY   = 68;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic signed [UNIT_W-1:0]  ux;
      logic signed [UNIT_W-1:0]  uy;
      logic signed [UNIT_W-1:0]  uz;
      logic        [LEN_W-1:0]   len;
      logic        [LEN_SQ_W-1:0] len_sq;
      logic                      zero;
   } norm_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   vn_req_if req_chan ();
   vn_rsp_if rsp_chan ();

   norm_t  norm_q[$];
   int     errors     = 0;
   int     cycle      = 0;
   int     sent       = 0;
   int     checked    = 0;
   int     zeros_seen = 0;
   bit     hold_rsp   = 1'b0;
   int     gap_left   = 0;
   int     burst_left = 0;

   vector3_normalize uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] rem, root, b;
      rem  = v;
      root = 0;
      b    = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem  = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] unit_of(logic [63:0] mag, bit neg, logic [63:0] len);
      logic [63:0] q;
      if (len == 0) return 32'd0;
      q = (mag << UNIT_FRAC_DEF) / len;
      if (neg) q = 64'd0 - q;
      return q[31:0];
   endfunction

   function automatic norm_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      norm_t       r;
      logic [63:0] ax, ay, az, sq, len;
      ax  = x[31] ? 64'(-{32'd0, x}) & 64'hFFFF_FFFF : {32'd0, x};
      ay  = y[31] ? 64'(-{32'd0, y}) & 64'hFFFF_FFFF : {32'd0, y};
      az  = z[31] ? 64'(-{32'd0, z}) & 64'hFFFF_FFFF : {32'd0, z};
      if (x == 32'h8000_0000) ax = 64'h8000_0000;
      if (y == 32'h8000_0000) ay = 64'h8000_0000;
      if (z == 32'h8000_0000) az = 64'h8000_0000;
      sq  = ax * ax + ay * ay + az * az;
      len = root_floor(sq);
      r.ux     = unit_of(ax, x[31], len);
      r.uy     = unit_of(ay, y[31], len);
      r.uz     = unit_of(az, z[31], len);
      r.len    = len[31:0];
      r.len_sq = sq;
      r.zero   = (len == 0);
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked);
   endtask

   task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      while (gap_left > 0) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         gap_left--;
      end
      req_chan.valid  <= 1'b1;
      req_chan.comp_x <= x;
      req_chan.comp_y <= y;
      req_chan.comp_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      norm_q.push_back(normalize(x, y, z));
      sent++;
      burst_left--;
   endtask

   task automatic idle_sender();
      req_chan.valid <= 1'b0;
   endtask

   // receiver stall pattern plus long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= (cycle % 11 < 3) ? 1'b0 : ($urandom_range(0, 4) != 0);
   end

   always @(posedge clock) begin
      norm_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (norm_q.size() == 0) begin
            errors++;
            $display("unexpected transaction on result channel");
         end else begin
            want = norm_q.pop_front();
            if (rsp_chan.unit_x !== want.ux) report("unit_x", rsp_chan.unit_x, want.ux);
            if (rsp_chan.unit_y !== want.uy) report("unit_y", rsp_chan.unit_y, want.uy);
            if (rsp_chan.unit_z !== want.uz) report("unit_z", rsp_chan.unit_z, want.uz);
            if (rsp_chan.length !== want.len) report("length", rsp_chan.length, want.len);
            if (rsp_chan.length_squared !== want.len_sq)
               report("length_squared", rsp_chan.length_squared, want.len_sq);
            if (rsp_chan.is_zero !== want.zero) report("is_zero", rsp_chan.is_zero, want.zero);
            if (want.zero) zeros_seen++;
            checked++;
         end
      end
   end

   task automatic test_corners();
      logic [31:0] v[6];
      v = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      send_vector(0, 0, 0);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 0, 0);
      send_vector(0, 32'h8000_0000, 0);
      send_vector(0, 0, 32'h7FFF_FFFF);
      send_vector(1, 0, 0);
      send_vector(0, 32'hFFFF_FFFF, 0);
      send_vector(0, 0, 1);
      send_vector(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
      send_vector(32'h0003_0000, 32'h0004_0000, 0);
      for (int i = 0; i < 12; i++)
         send_vector(v[$urandom_range(0, 5)], v[$urandom_range(0, 5)], v[$urandom_range(0, 5)]);
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 512)) - 256);
         2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
         3: return 32'h8000_0000 ^ $urandom_range(0, 3);
         4: return 32'd0;
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         test_random(120);
      join
   endtask

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.comp_x = '0;
      req_chan.comp_y = '0;
      req_chan.comp_z = '0;
      rsp_chan.ready  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random(300);
      test_backpressure();
      test_random(310);
      idle_sender();
      while (norm_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("sent %0d vectors, checked %0d results, %0d zero vectors", sent, checked,
               zeros_seen);
      $display("covered corner components, random vectors and a long result stall");
      if (errors == 0 && norm_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ----- vector3_normalize.f -----
rtl/vn_pkg.sv
rtl/vn_if.sv
rtl/vn_sqrt_cell.sv
rtl/vn_div_cell.sv
rtl/vector3_normalize.sv
tb/sv/tb_vector3_normalize.sv
